/* design/sltw_pkg.sv */
// Package for the skeleton world-transform block: payload structs, constants,
// a saturation helper and the sequencer state type. No dependencies.
package sltw_pkg;

   localparam int unsigned MaxJointsDefault = 256;
   localparam logic [15:0] RootMark = 16'hffff;
   localparam logic signed [31:0] OneQ = 32'sd65536;
   localparam logic [8:0] JointCountReset = 9'd256;

   typedef enum logic {
      CMD_ROOT = 1'b0,
      CMD_JOINT = 1'b1
   } command_type;

   typedef struct packed {
      command_type command;
      logic signed [31:0] quat_x;
      logic signed [31:0] quat_y;
      logic signed [31:0] quat_z;
      logic signed [31:0] quat_w;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] scale_x;
      logic signed [31:0] scale_y;
      logic signed [31:0] scale_z;
      logic [15:0] parent_index;
   } req_type;

   typedef struct packed {
      logic signed [31:0] basis_00;
      logic signed [31:0] basis_10;
      logic signed [31:0] basis_20;
      logic signed [31:0] basis_01;
      logic signed [31:0] basis_11;
      logic signed [31:0] basis_21;
      logic signed [31:0] basis_02;
      logic signed [31:0] basis_12;
      logic signed [31:0] basis_22;
      logic signed [31:0] world_tx;
      logic signed [31:0] world_ty;
      logic signed [31:0] world_tz;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_QMUL,
      ST_ROT,
      ST_LOC,
      ST_RD,
      ST_RECIP,
      ST_COMP,
      ST_TRANS,
      ST_MAT,
      ST_WR,
      ST_OUT
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7fffffff;
      if (v < -66'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

endpackage

/* design/sltw_recip.sv */
// Iterative restoring divider: 2^32 / s, truncated toward zero, saturated.
// Depends on sltw_pkg.
module sltw_recip
   import sltw_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [31:0] divisor,
   output logic done,
   output logic signed [31:0] quotient
);
   logic [32:0] rem_ff, rem_in;
   logic [32:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic neg_ff, neg_in, zero_ff, zero_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [33:0] trial;

   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; dvs_in = dvs_ff;
      neg_in = neg_ff; zero_in = zero_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff, quo_ff[32]} - {2'b0, dvs_ff};
      if (start) begin
         dvs_in = divisor[31] ? 32'(-divisor) : divisor;
         neg_in = divisor[31];
         zero_in = (divisor == 32'sd0);
         rem_in = '0;
         quo_in = {1'b1, 32'd0};
         cnt_in = 6'd33;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[33]) begin
            rem_in = trial[32:0];
            quo_in = {quo_ff[31:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], quo_ff[32]};
            quo_in = {quo_ff[31:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in; quo_ff <= quo_in; dvs_ff <= dvs_in;
      neg_ff <= neg_in; zero_ff <= zero_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   always_comb begin
      logic signed [34:0] sq;
      sq = neg_ff ? -$signed({2'b0, quo_ff}) : $signed({2'b0, quo_ff});
      if (zero_ff) quotient = 32'sh7fffffff;
      else quotient = sat32(66'(sq));
   end
   assign done = done_ff;
endmodule

/* design/skeleton_local_to_world_matrices.sv */
// Top level of the skeleton world-transform block: sequencer, one shared
// multiplier, world and scale memories. Depends on sltw_pkg and sltw_recip.
// Sequence: a joint item runs quaternion products, rotation, local scaling, a parent fetch,
//   three reciprocals, composition, translation, matrix product and write-back before
//   rsp_valid rises, using 63 products on the single 32x32 multiplier.
// Throughput: one item at a time; a root item or an ignored joint ends after local scaling
//   with no result; a stalled result holds only the next result.
// Reset: root matrix to identity, root scale to one, joint counter cleared, joint limit to
//   256; memories stay undefined until written.
module skeleton_local_to_world_matrices
   import sltw_pkg::*;
#(
   parameter int unsigned MAX_JOINTS = MaxJointsDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rsp_type rsp_data,
   input  logic csr_write,
   input  logic [8:0] csr_data
);
   localparam int unsigned IdxW = $clog2(MAX_JOINTS);
   localparam int unsigned WAddrW = $clog2(MAX_JOINTS * 12);
   localparam int unsigned SAddrW = $clog2(MAX_JOINTS * 3);

   logic signed [31:0] world_mem [MAX_JOINTS * 12];
   logic signed [31:0] scale_mem [MAX_JOINTS * 3];
   logic signed [31:0] wrd_ff, srd_ff;

   state_type state_ff, state_in;
   req_type item_ff;
   logic [8:0] count_ff;
   logic [9:0] jc_ff, jc_in;
   logic signed [31:0] root_ff [12];
   logic signed [31:0] rscale_ff [3];
   logic signed [47:0] q_ff [9];
   logic signed [31:0] rot_ff [9];
   logic signed [31:0] loc_ff [9];
   logic signed [31:0] par_ff [12];
   logic signed [31:0] psc_ff [3];
   logic signed [31:0] rc_ff [3];
   logic signed [31:0] comp_ff [9];
   logic signed [31:0] wm_ff [12];
   logic signed [65:0] acc_ff;
   logic [4:0] step_ff;
   logic [1:0] kk_ff;
   logic use_root_ff;
   logic [IdxW-1:0] pidx_ff;
   logic out_valid_ff;
   rsp_type out_ff;

   logic signed [31:0] ma, mb;
   logic signed [63:0] prod;
   logic signed [47:0] fl;
   logic signed [31:0] qv [4];
   logic signed [31:0] sc [3];
   logic signed [31:0] pv [3];
   logic [12:0] limit;
   logic accept;
   logic out_free;
   logic rstart, rdone;
   logic signed [31:0] rq;
   logic [1:0] sc_c, sc_r;
   logic signed [31:0] rsel;

   sltw_recip u_recip (
      .clock(clock), .reset(reset), .start(rstart),
      .divisor(rsel), .done(rdone), .quotient(rq)
   );

   assign qv[0] = item_ff.quat_x; assign qv[1] = item_ff.quat_y;
   assign qv[2] = item_ff.quat_z; assign qv[3] = item_ff.quat_w;
   assign sc[0] = item_ff.scale_x; assign sc[1] = item_ff.scale_y;
   assign sc[2] = item_ff.scale_z;
   assign pv[0] = item_ff.pos_x; assign pv[1] = item_ff.pos_y;
   assign pv[2] = item_ff.pos_z;
   assign limit = (13'(count_ff) < 13'(MAX_JOINTS)) ? 13'(count_ff) : 13'(MAX_JOINTS);
   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign out_free = !out_valid_ff || !rsp_stall;
   assign rsel = psc_ff[step_ff[1:0]];
   assign rstart = (state_ff == ST_RECIP) && (kk_ff == 2'd0);

   always_comb begin
      case (step_ff)
         5'd0, 5'd1, 5'd2: sc_c = 2'd0;
         5'd3, 5'd4, 5'd5: sc_c = 2'd1;
         default: sc_c = 2'd2;
      endcase
      case (step_ff)
         5'd0, 5'd3, 5'd6: sc_r = 2'd0;
         5'd1, 5'd4, 5'd7: sc_r = 2'd1;
         default: sc_r = 2'd2;
      endcase
   end

   // operand select for the shared multiplier
   always_comb begin
      ma = '0; mb = '0;
      case (state_ff)
         ST_QMUL: begin
            case (step_ff)
               5'd0: begin ma = qv[0]; mb = qv[0]; end
               5'd1: begin ma = qv[1]; mb = qv[1]; end
               5'd2: begin ma = qv[2]; mb = qv[2]; end
               5'd3: begin ma = qv[0]; mb = qv[1]; end
               5'd4: begin ma = qv[0]; mb = qv[2]; end
               5'd5: begin ma = qv[1]; mb = qv[2]; end
               5'd6: begin ma = qv[0]; mb = qv[3]; end
               5'd7: begin ma = qv[1]; mb = qv[3]; end
               default: begin ma = qv[2]; mb = qv[3]; end
            endcase
         end
         ST_LOC: begin ma = rot_ff[4'(step_ff)]; mb = sc[sc_c]; end
         ST_COMP: begin ma = par_ff[4'(step_ff)]; mb = rc_ff[sc_c]; end
         ST_TRANS: begin ma = par_ff[4'(kk_ff) * 4'd3 + 4'(step_ff)]; mb = pv[kk_ff]; end
         ST_MAT: begin
            ma = comp_ff[4'(kk_ff) * 4'd3 + 4'(sc_r)];
            mb = loc_ff[4'(sc_c) * 4'd3 + 4'(kk_ff)];
         end
         default: begin ma = '0; mb = '0; end
      endcase
   end
   assign prod = ma * mb;
   assign fl = 48'(prod >>> 16);

   always_comb begin
      state_in = state_ff;
      jc_in = jc_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_QMUL;
         ST_QMUL: if (step_ff == 5'd8) state_in = ST_ROT;
         ST_ROT: state_in = ST_LOC;
         ST_LOC: begin
            if (step_ff == 5'd8) begin
               if (item_ff.command == CMD_ROOT) begin
                  state_in = ST_IDLE; jc_in = '0;
               end else if (13'(jc_ff) >= limit) state_in = ST_IDLE;
               else state_in = ST_RD;
            end
         end
         ST_RD: if (step_ff == 5'd15) state_in = ST_RECIP;
         ST_RECIP: if (rdone && step_ff == 5'd2) state_in = ST_COMP;
         ST_COMP: if (step_ff == 5'd8) state_in = ST_TRANS;
         ST_TRANS: if (step_ff == 5'd2 && kk_ff == 2'd3) state_in = ST_MAT;
         ST_MAT: if (step_ff == 5'd8 && kk_ff == 2'd3) state_in = ST_WR;
         ST_WR: if (step_ff == 5'd14) begin
            state_in = ST_OUT; jc_in = jc_ff + 10'd1;
         end
         ST_OUT: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // memory ports: read during ST_RD, write during ST_WR
   logic [WAddrW-1:0] waddr;
   logic [SAddrW-1:0] saddr;
   logic [IdxW-1:0] jidx;
   assign jidx = IdxW'(jc_ff);
   always_comb begin
      if (state_ff == ST_WR) begin
         waddr = WAddrW'(jidx) * WAddrW'(12) + WAddrW'(step_ff[3:0]);
         saddr = SAddrW'(jidx) * SAddrW'(3) + SAddrW'(step_ff[1:0]);
      end else begin
         waddr = WAddrW'(pidx_ff) * WAddrW'(12) + WAddrW'(step_ff[3:0]);
         saddr = SAddrW'(pidx_ff) * SAddrW'(3) + SAddrW'(step_ff[1:0]);
      end
   end
   always_ff @(posedge clock) begin
      if (state_ff == ST_WR && step_ff < 5'd12) world_mem[waddr] <= wm_ff[4'(step_ff)];
      if (state_ff == ST_WR && step_ff < 5'd3) scale_mem[saddr] <= sc[2'(step_ff)];
      wrd_ff <= world_mem[waddr];
      srd_ff <= scale_mem[saddr];
   end

   always_ff @(posedge clock) begin
      logic signed [33:0] t;
      if (accept) begin
         item_ff <= req_data;
         use_root_ff <= (req_data.parent_index == RootMark) ||
                        ({1'b0, req_data.parent_index} >= 17'(jc_ff));
         pidx_ff <= req_data.parent_index[IdxW-1:0];
      end
      if (reset) begin
         for (int i = 0; i < 12; i++)
            root_ff[i] <= (i == 0 || i == 4 || i == 8) ? OneQ : 32'sd0;
         for (int i = 0; i < 3; i++) rscale_ff[i] <= OneQ;
      end
      case (state_ff)
         ST_QMUL: q_ff[4'(step_ff)] <= fl;
         ST_ROT: begin
            rot_ff[0] <= sat32(66'(OneQ) - 66'sd2 * (66'(q_ff[1]) + 66'(q_ff[2])));
            rot_ff[1] <= sat32(66'sd2 * (66'(q_ff[3]) + 66'(q_ff[8])));
            rot_ff[2] <= sat32(66'sd2 * (66'(q_ff[4]) - 66'(q_ff[7])));
            rot_ff[3] <= sat32(66'sd2 * (66'(q_ff[3]) - 66'(q_ff[8])));
            rot_ff[4] <= sat32(66'(OneQ) - 66'sd2 * (66'(q_ff[0]) + 66'(q_ff[2])));
            rot_ff[5] <= sat32(66'sd2 * (66'(q_ff[5]) + 66'(q_ff[6])));
            rot_ff[6] <= sat32(66'sd2 * (66'(q_ff[4]) + 66'(q_ff[7])));
            rot_ff[7] <= sat32(66'sd2 * (66'(q_ff[5]) - 66'(q_ff[6])));
            rot_ff[8] <= sat32(66'(OneQ) - 66'sd2 * (66'(q_ff[0]) + 66'(q_ff[1])));
         end
         ST_LOC: begin
            loc_ff[4'(step_ff)] <= sat32(66'(fl));
            if (item_ff.command == CMD_ROOT && !reset) begin
               root_ff[4'(step_ff)] <= sat32(66'(fl));
               if (step_ff < 5'd3) begin
                  root_ff[4'd9 + 4'(step_ff)] <= pv[2'(step_ff)];
                  rscale_ff[2'(step_ff)] <= sc[2'(step_ff)];
               end
            end
         end
         ST_RD: begin
            if (step_ff >= 5'd1 && step_ff <= 5'd12)
               par_ff[4'(step_ff - 5'd1)] <= use_root_ff ? root_ff[4'(step_ff - 5'd1)] : wrd_ff;
            if (step_ff >= 5'd1 && step_ff <= 5'd3)
               psc_ff[2'(step_ff - 5'd1)] <= use_root_ff ? rscale_ff[2'(step_ff - 5'd1)] : srd_ff;
         end
         ST_RECIP: if (rdone) rc_ff[2'(step_ff)] <= rq;
         ST_COMP: comp_ff[4'(step_ff)] <= sat32(66'(fl));
         ST_TRANS: begin
            if (kk_ff == 2'd3) wm_ff[4'd9 + 4'(step_ff)] <= sat32(acc_ff);
         end
         ST_MAT: begin
            if (kk_ff == 2'd3) wm_ff[4'(step_ff)] <= sat32(acc_ff);
         end
         default: ;
      endcase
      t = '0;
      if (state_ff == ST_TRANS || state_ff == ST_MAT) begin
         if (kk_ff == 2'd3)
            acc_ff <= (state_ff == ST_TRANS && step_ff != 5'd2) ?
                      66'(par_ff[4'd10 + 4'(step_ff)]) : 66'sd0;
         else acc_ff <= acc_ff + 66'(fl) + 66'(t);
      end else acc_ff <= 66'(par_ff[9]);
      if (state_ff == ST_OUT && out_free) begin
         out_ff <= {wm_ff[0], wm_ff[1], wm_ff[2], wm_ff[3], wm_ff[4], wm_ff[5],
                    wm_ff[6], wm_ff[7], wm_ff[8], wm_ff[9], wm_ff[10], wm_ff[11]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         jc_ff <= '0;
         count_ff <= JointCountReset;
         step_ff <= '0;
         kk_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         jc_ff <= jc_in;
         if (csr_write) count_ff <= csr_data;
         if (state_ff == ST_OUT && out_free) out_valid_ff <= 1'b1;
         else if (out_valid_ff && !rsp_stall) out_valid_ff <= 1'b0;
         if (state_in != state_ff) begin
            step_ff <= '0; kk_ff <= '0;
         end else if (state_ff == ST_RECIP) begin
            kk_ff <= rdone ? 2'd0 : 2'd1;
            if (rdone) step_ff <= step_ff + 5'd1;
         end else if (state_ff == ST_TRANS || state_ff == ST_MAT) begin
            if (kk_ff == 2'd3) begin
               kk_ff <= '0; step_ff <= step_ff + 5'd1;
            end else kk_ff <= kk_ff + 2'd1;
         end else step_ff <= step_ff + 5'd1;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed or dropped");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |=> rsp_valid)
      else $error("result lost");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR && state_in == ST_OUT) |=> (jc_ff == $past(jc_ff) + 10'd1))
      else $error("joint counter did not advance");
endmodule
